// File: sv/psp_pkg.sv
`timescale 1ns / 1ps

package psp_pkg;

    // Width of the axis-order accumulator; orders above 2**AXIS_BITS-1 are rejected
    localparam int AXIS_BITS = 8;
    localparam logic [AXIS_BITS-1:0] AXIS_MAX = {AXIS_BITS{1'b1}};

    // Accumulator candidate width: holds accum*10 + 9
    localparam int ACC_W = AXIS_BITS + 4;

    localparam int CH_W    = 8;
    localparam int KIND_W  = 5;
    localparam int GORD_W  = 10;
    localparam int AXIS_W  = 8;
    localparam int IRREP_W = 9;
    localparam int POS_W   = 3;

    // Width for order and irrep arithmetic: holds 4*n and the fixed group orders
    localparam int CALC_W = (AXIS_BITS + 2 > GORD_W) ? AXIS_BITS + 2 : GORD_W;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } sym_t;

    typedef struct packed {
        logic               valid_res;
        logic [KIND_W-1:0]  group_kind;
        logic [GORD_W-1:0]  group_order;
        logic [AXIS_W-1:0]  axis_order;
        logic [IRREP_W-1:0] irrep_count;
    } res_t;

    typedef enum logic [2:0] {
        LEAD_NONE  = 3'd0,
        LEAD_C     = 3'd1,
        LEAD_D     = 3'd2,
        LEAD_S     = 3'd3,
        LEAD_T     = 3'd4,
        LEAD_O     = 3'd5,
        LEAD_I     = 3'd6,
        LEAD_OTHER = 3'd7
    } lead_t;

    typedef enum logic [2:0] {
        SUF_NONE  = 3'd0,
        SUF_V     = 3'd1,
        SUF_H     = 3'd2,
        SUF_D     = 3'd3,
        SUF_I     = 3'd4,
        SUF_S     = 3'd5,
        SUF_OTHER = 3'd6
    } suffix_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_C1  = 5'd0,
        KIND_CI  = 5'd1,
        KIND_CS  = 5'd2,
        KIND_CN  = 5'd3,
        KIND_CNV = 5'd4,
        KIND_CNH = 5'd5,
        KIND_DN  = 5'd6,
        KIND_DND = 5'd7,
        KIND_DNH = 5'd8,
        KIND_SN  = 5'd9,
        KIND_T   = 5'd10,
        KIND_TD  = 5'd11,
        KIND_TH  = 5'd12,
        KIND_O   = 5'd13,
        KIND_OH  = 5'd14,
        KIND_I   = 5'd15,
        KIND_IH  = 5'd16
    } kind_t;

    // Parser state carried between characters of one symbol
    typedef struct packed {
        logic [POS_W-1:0]     position;
        lead_t                lead;
        logic [AXIS_BITS-1:0] axis_accum;
        logic                 axis_overflow;
        logic                 digit_seen;
        suffix_t              suffix;
        logic                 syntax_error;
    } scan_t;

    localparam scan_t SCAN_RESET = '{
        position:      '0,
        lead:          LEAD_NONE,
        axis_accum:    '0,
        axis_overflow: 1'b0,
        digit_seen:    1'b0,
        suffix:        SUF_NONE,
        syntax_error:  1'b0
    };

    // Fold A..Z to lower case, leave other bytes alone
    function automatic logic [CH_W-1:0] fold_case(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] r;
        r = c;
        if (c >= "A" && c <= "Z")
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic lead_t lead_code(input logic [CH_W-1:0] c);
        lead_t r;
        unique case (c)
            "c":     r = LEAD_C;
            "d":     r = LEAD_D;
            "s":     r = LEAD_S;
            "t":     r = LEAD_T;
            "o":     r = LEAD_O;
            "i":     r = LEAD_I;
            default: r = LEAD_OTHER;
        endcase
        return r;
    endfunction

    function automatic suffix_t suffix_code(input logic [CH_W-1:0] c);
        suffix_t r;
        unique case (c)
            "v":     r = SUF_V;
            "h":     r = SUF_H;
            "d":     r = SUF_D;
            "i":     r = SUF_I;
            "s":     r = SUF_S;
            default: r = SUF_OTHER;
        endcase
        return r;
    endfunction

endpackage

// File: sv/point_group_symbol_parser.sv
`timescale 1ns / 1ps

// Schoenflies point-group symbol parser. Feed the symbol one character per
// request on sym (either case), with last set on its final character; one
// result per symbol appears on res, describing the group (valid flag, kind,
// order, principal axis order, irrep count), or all zeros if the symbol is
// not a known group. One character is accepted every cycle unless a final
// character is stalled: each character passes through an input register
// and then updates the parser state, and the result register is loaded,
// raising res_valid, as the final character leaves the input register.
// Only the final character of a symbol waits on a result still held in the
// output register; other characters keep flowing.
module point_group_symbol_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sym_valid,
    output logic          sym_ready,
    input  psp_pkg::sym_t sym,
    output logic          res_valid,
    input  logic          res_ready,
    output psp_pkg::res_t res
);

    logic           held_valid;
    psp_pkg::sym_t  held;
    logic           advance;
    psp_pkg::scan_t scan_next;
    psp_pkg::res_t  res_comb;
    logic           res_valid_reg;
    psp_pkg::res_t  res_reg;

    // Final character moves only when the result slot is free
    assign advance = held_valid && (!held.last || !res_valid_reg || res_ready);

    psp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .sym_valid  (sym_valid),
        .sym_ready  (sym_ready),
        .sym        (sym),
        .advance    (advance),
        .held_valid (held_valid),
        .held       (held)
    );

    psp_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .held      (held),
        .scan_next (scan_next)
    );

    psp_finish u_finish (
        .st  (scan_next),
        .res (res_comb)
    );

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance && held.last)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && held.last)
        begin
            res_reg <= res_comb;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: sv/psp_in_reg.sv
`timescale 1ns / 1ps

module psp_in_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sym_valid,
    output logic          sym_ready,
    input  psp_pkg::sym_t sym,
    input  logic          advance,
    output logic          held_valid,
    output psp_pkg::sym_t held
);

    logic          held_valid_reg;
    psp_pkg::sym_t held_reg;

    // Take a new request whenever the slot is empty or drains this cycle
    assign sym_ready = !held_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else if (sym_ready)
        begin
            held_valid_reg <= sym_valid;
        end
    end

    // Hold the character already folded to lower case
    always_ff @(posedge clk)
    begin
        if (sym_valid && sym_ready)
        begin
            held_reg.ch   <= psp_pkg::fold_case(sym.ch);
            held_reg.last <= sym.last;
        end
    end

    assign held_valid = held_valid_reg;
    assign held       = held_reg;

endmodule

// File: sv/psp_scan.sv
`timescale 1ns / 1ps

module psp_scan (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  psp_pkg::sym_t           held,
    output psp_pkg::scan_t          scan_next
);

    psp_pkg::scan_t                 st_reg;
    psp_pkg::scan_t                 st_next;
    logic                           is_digit;
    logic [psp_pkg::ACC_W-1:0]      acc_wide;
    logic [psp_pkg::ACC_W-1:0]      cand;

    assign is_digit = (held.ch >= "0") && (held.ch <= "9");
    assign acc_wide = psp_pkg::ACC_W'(st_reg.axis_accum);
    // accum * 10 + digit
    assign cand = (acc_wide << 3) + (acc_wide << 1)
                + psp_pkg::ACC_W'(held.ch - "0");

    // Fold one character into the parser state
    always_comb
    begin
        st_next = st_reg;
        if (st_reg.position == '0)
        begin
            st_next.lead = psp_pkg::lead_code(held.ch);
            if (st_next.lead == psp_pkg::LEAD_OTHER)
            begin
                st_next.syntax_error = 1'b1;
            end
        end
        else
        begin
            unique case (st_reg.lead) inside
                psp_pkg::LEAD_C, psp_pkg::LEAD_D, psp_pkg::LEAD_S:
                begin
                    if (st_reg.suffix == psp_pkg::SUF_NONE)
                    begin
                        if (is_digit)
                        begin
                            if (!st_reg.axis_overflow)
                            begin
                                if (cand > psp_pkg::ACC_W'(psp_pkg::AXIS_MAX))
                                begin
                                    st_next.axis_overflow = 1'b1;
                                end
                                else
                                begin
                                    st_next.axis_accum = cand[psp_pkg::AXIS_BITS-1:0];
                                end
                            end
                            st_next.digit_seen = 1'b1;
                        end
                        else
                        begin
                            st_next.suffix = psp_pkg::suffix_code(held.ch);
                        end
                    end
                end
                psp_pkg::LEAD_T, psp_pkg::LEAD_O, psp_pkg::LEAD_I:
                begin
                    if (st_reg.position == psp_pkg::POS_W'(1))
                    begin
                        st_next.suffix = psp_pkg::suffix_code(held.ch);
                    end
                end
                default:
                begin
                    st_next = st_reg;
                end
            endcase
        end
        if (st_reg.position != psp_pkg::POS_MAX)
        begin
            st_next.position = st_reg.position + psp_pkg::POS_W'(1);
        end
    end

    // Advance per character; drop back to reset after the final one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= psp_pkg::SCAN_RESET;
        end
        else if (advance)
        begin
            st_reg <= held.last ? psp_pkg::SCAN_RESET : st_next;
        end
    end

    assign scan_next = st_next;

endmodule

// File: sv/psp_finish.sv
`timescale 1ns / 1ps

module psp_finish (
    input  psp_pkg::scan_t st,
    output psp_pkg::res_t  res
);

    logic [psp_pkg::CALC_W-1:0] n;
    logic                       axis_ok;
    logic [psp_pkg::CALC_W-1:0] nab;
    logic [psp_pkg::CALC_W-1:0] ne;
    logic                       ok;
    psp_pkg::kind_t             kind;
    logic [psp_pkg::CALC_W-1:0] g;
    logic [psp_pkg::CALC_W-1:0] ax;
    logic [psp_pkg::CALC_W-1:0] nir;
    logic                       exact2;

    assign n       = psp_pkg::CALC_W'(st.axis_accum);
    assign axis_ok = st.digit_seen && !st.axis_overflow && (st.axis_accum != '0);
    assign nab     = n[0] ? psp_pkg::CALC_W'(1) : psp_pkg::CALC_W'(2);
    assign ne      = !axis_ok ? '0 :
                     n[0] ? (n >> 1) : ((n >> 1) - psp_pkg::CALC_W'(1));
    assign exact2  = (st.position == psp_pkg::POS_W'(2));

    // Classify the symbol and work out order and irrep count
    always_comb
    begin
        ok   = 1'b0;
        kind = psp_pkg::KIND_C1;
        g    = '0;
        ax   = '0;
        nir  = '0;
        if (!st.syntax_error)
        begin
            unique case (st.lead)
                psp_pkg::LEAD_C:
                begin
                    if (exact2 && st.suffix == psp_pkg::SUF_I)
                    begin
                        ok = 1'b1; kind = psp_pkg::KIND_CI;
                        g = psp_pkg::CALC_W'(2); ax = psp_pkg::CALC_W'(2);
                        nir = psp_pkg::CALC_W'(2);
                    end
                    else if (exact2 && st.suffix == psp_pkg::SUF_S)
                    begin
                        ok = 1'b1; kind = psp_pkg::KIND_CS;
                        g = psp_pkg::CALC_W'(2); ax = '0;
                        nir = psp_pkg::CALC_W'(2);
                    end
                    else if (exact2 && axis_ok && n == psp_pkg::CALC_W'(1)
                             && st.suffix == psp_pkg::SUF_NONE)
                    begin
                        ok = 1'b1; kind = psp_pkg::KIND_C1;
                        g = psp_pkg::CALC_W'(1); ax = psp_pkg::CALC_W'(1);
                        nir = psp_pkg::CALC_W'(1);
                    end
                    else if (axis_ok && st.suffix == psp_pkg::SUF_NONE)
                    begin
                        ok = 1'b1; kind = psp_pkg::KIND_CN;
                        g = n; ax = n; nir = nab + ne;
                    end
                    else if (axis_ok && st.suffix == psp_pkg::SUF_V)
                    begin
                        ok = 1'b1; kind = psp_pkg::KIND_CNV;
                        g = n << 1; ax = n; nir = (nab << 1) + ne;
                    end
                    else if (axis_ok && st.suffix == psp_pkg::SUF_H)
                    begin
                        ok = 1'b1; kind = psp_pkg::KIND_CNH;
                        g = n << 1; ax = n; nir = (nab + ne) << 1;
                    end
                end
                psp_pkg::LEAD_D:
                begin
                    if (axis_ok && st.suffix == psp_pkg::SUF_NONE)
                    begin
                        ok = 1'b1; kind = psp_pkg::KIND_DN;
                        g = n << 1; ax = n; nir = (nab << 1) + ne;
                    end
                    else if (axis_ok && st.suffix == psp_pkg::SUF_D)
                    begin
                        ok = 1'b1; kind = psp_pkg::KIND_DND;
                        g = n << 2; ax = n; nir = n + psp_pkg::CALC_W'(3);
                    end
                    else if (axis_ok && st.suffix == psp_pkg::SUF_H)
                    begin
                        ok = 1'b1; kind = psp_pkg::KIND_DNH;
                        g = n << 2; ax = n; nir = (nab << 2) + (ne << 1);
                    end
                end
                psp_pkg::LEAD_S:
                begin
                    if (axis_ok && !n[0])
                    begin
                        ok = 1'b1; kind = psp_pkg::KIND_SN;
                        g = n; ax = n; nir = (n >> 1) + psp_pkg::CALC_W'(1);
                    end
                end
                psp_pkg::LEAD_T:
                begin
                    ax = psp_pkg::CALC_W'(1);
                    if (st.suffix == psp_pkg::SUF_NONE)
                    begin
                        ok = 1'b1; kind = psp_pkg::KIND_T;
                        g = psp_pkg::CALC_W'(12); nir = psp_pkg::CALC_W'(3);
                    end
                    else if (st.suffix == psp_pkg::SUF_D)
                    begin
                        ok = 1'b1; kind = psp_pkg::KIND_TD;
                        g = psp_pkg::CALC_W'(24); nir = psp_pkg::CALC_W'(5);
                    end
                    else if (st.suffix == psp_pkg::SUF_H)
                    begin
                        ok = 1'b1; kind = psp_pkg::KIND_TH;
                        g = psp_pkg::CALC_W'(24); nir = psp_pkg::CALC_W'(6);
                    end
                end
                psp_pkg::LEAD_O:
                begin
                    ax = psp_pkg::CALC_W'(1);
                    if (st.suffix == psp_pkg::SUF_NONE)
                    begin
                        ok = 1'b1; kind = psp_pkg::KIND_O;
                        g = psp_pkg::CALC_W'(24); nir = psp_pkg::CALC_W'(5);
                    end
                    else if (st.suffix == psp_pkg::SUF_H)
                    begin
                        ok = 1'b1; kind = psp_pkg::KIND_OH;
                        g = psp_pkg::CALC_W'(48); nir = psp_pkg::CALC_W'(10);
                    end
                end
                psp_pkg::LEAD_I:
                begin
                    ax = psp_pkg::CALC_W'(1);
                    if (st.suffix == psp_pkg::SUF_NONE)
                    begin
                        ok = 1'b1; kind = psp_pkg::KIND_I;
                        g = psp_pkg::CALC_W'(60); nir = psp_pkg::CALC_W'(5);
                    end
                    else if (st.suffix == psp_pkg::SUF_H)
                    begin
                        ok = 1'b1; kind = psp_pkg::KIND_IH;
                        g = psp_pkg::CALC_W'(120); nir = psp_pkg::CALC_W'(10);
                    end
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
        end
    end

    // Zero every field of an invalid result
    always_comb
    begin
        res.valid_res   = ok;
        res.group_kind  = ok ? kind : psp_pkg::KIND_C1;
        res.group_order = ok ? psp_pkg::GORD_W'(g) : '0;
        res.axis_order  = ok ? psp_pkg::AXIS_W'(ax) : '0;
        res.irrep_count = ok ? psp_pkg::IRREP_W'(nir) : '0;
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int QUIET_LIMIT = 5000;
    localparam int PHASE_CHARS = 175;

    // Parser state mirrored on the checker side
    typedef struct packed {
        logic [2:0]                    pos;
        psp_pkg::lead_t                lead;
        logic [psp_pkg::AXIS_BITS-1:0] acc;
        logic                          ovf;
        logic                          dig;
        psp_pkg::suffix_t              suf;
        logic                          bad;
    } parse_state_t;

    localparam parse_state_t SCAN_IDLE = '{
        pos:  '0,
        lead: psp_pkg::LEAD_NONE,
        acc:  '0,
        ovf:  1'b0,
        dig:  1'b0,
        suf:  psp_pkg::SUF_NONE,
        bad:  1'b0
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sym_valid = 1'b0;
    logic sym_ready;
    psp_pkg::sym_t sym = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    psp_pkg::res_t res;

    parse_state_t scan = SCAN_IDLE;
    psp_pkg::sym_t chars_to_send[$];
    psp_pkg::res_t groups_due[$];
    psp_pkg::res_t group_want;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned send_idle_by_phase[4] = '{0, 66, 0, 18};
    int unsigned recv_stall_by_phase[4] = '{0, 0, 66, 18};
    int failures = 0;
    int quiet_cycles = 0;

    point_group_symbol_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .sym       (sym),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always #5 clk = ~clk;

    function automatic psp_pkg::lead_t lead_of(logic [7:0] c);
        case (c)
            "c":     return psp_pkg::LEAD_C;
            "d":     return psp_pkg::LEAD_D;
            "s":     return psp_pkg::LEAD_S;
            "t":     return psp_pkg::LEAD_T;
            "o":     return psp_pkg::LEAD_O;
            "i":     return psp_pkg::LEAD_I;
            default: return psp_pkg::LEAD_OTHER;
        endcase
    endfunction

    function automatic psp_pkg::suffix_t suffix_of(logic [7:0] c);
        case (c)
            "v":     return psp_pkg::SUF_V;
            "h":     return psp_pkg::SUF_H;
            "d":     return psp_pkg::SUF_D;
            "i":     return psp_pkg::SUF_I;
            "s":     return psp_pkg::SUF_S;
            default: return psp_pkg::SUF_OTHER;
        endcase
    endfunction

    // Describe the group named by a completed symbol
    function automatic psp_pkg::res_t classify(parse_state_t s);
        int unsigned n;
        int unsigned nab;
        int unsigned ne;
        int unsigned g;
        int unsigned ax;
        int unsigned nir;
        logic axis_ok;
        logic ok;
        psp_pkg::kind_t k;
        psp_pkg::res_t r;
        n = s.acc;
        axis_ok = s.dig && !s.ovf && (n != 0);
        nab = n[0] ? 1 : 2;
        ne = !axis_ok ? 0 : (n[0] ? n / 2 : n / 2 - 1);
        ok = 1'b1;
        k = psp_pkg::KIND_C1;
        g = 0;
        ax = n;
        nir = 0;
        if (s.bad)
        begin
            ok = 1'b0;
        end
        else
        begin
            case (s.lead)
                psp_pkg::LEAD_C:
                begin
                    if (s.pos == 3'd2 && s.suf == psp_pkg::SUF_I)
                    begin
                        k = psp_pkg::KIND_CI; g = 2; ax = 2; nir = 2;
                    end
                    else if (s.pos == 3'd2 && s.suf == psp_pkg::SUF_S)
                    begin
                        k = psp_pkg::KIND_CS; g = 2; ax = 0; nir = 2;
                    end
                    else if (s.pos == 3'd2 && axis_ok && n == 1
                             && s.suf == psp_pkg::SUF_NONE)
                    begin
                        k = psp_pkg::KIND_C1; g = 1; ax = 1; nir = 1;
                    end
                    else if (!axis_ok)
                        ok = 1'b0;
                    else if (s.suf == psp_pkg::SUF_NONE)
                    begin
                        k = psp_pkg::KIND_CN; g = n; nir = nab + ne;
                    end
                    else if (s.suf == psp_pkg::SUF_V)
                    begin
                        k = psp_pkg::KIND_CNV; g = 2 * n; nir = 2 * nab + ne;
                    end
                    else if (s.suf == psp_pkg::SUF_H)
                    begin
                        k = psp_pkg::KIND_CNH; g = 2 * n; nir = 2 * (nab + ne);
                    end
                    else
                        ok = 1'b0;
                end
                psp_pkg::LEAD_D:
                begin
                    if (!axis_ok)
                        ok = 1'b0;
                    else if (s.suf == psp_pkg::SUF_NONE)
                    begin
                        k = psp_pkg::KIND_DN; g = 2 * n; nir = 2 * nab + ne;
                    end
                    else if (s.suf == psp_pkg::SUF_D)
                    begin
                        k = psp_pkg::KIND_DND; g = 4 * n; nir = n + 3;
                    end
                    else if (s.suf == psp_pkg::SUF_H)
                    begin
                        k = psp_pkg::KIND_DNH; g = 4 * n; nir = 4 * nab + 2 * ne;
                    end
                    else
                        ok = 1'b0;
                end
                psp_pkg::LEAD_S:
                begin
                    if (!axis_ok || n[0])
                        ok = 1'b0;
                    else
                    begin
                        k = psp_pkg::KIND_SN; g = n; nir = n / 2 + 1;
                    end
                end
                psp_pkg::LEAD_T:
                begin
                    ax = 1;
                    if (s.suf == psp_pkg::SUF_NONE)
                    begin
                        k = psp_pkg::KIND_T; g = 12; nir = 3;
                    end
                    else if (s.suf == psp_pkg::SUF_D)
                    begin
                        k = psp_pkg::KIND_TD; g = 24; nir = 5;
                    end
                    else if (s.suf == psp_pkg::SUF_H)
                    begin
                        k = psp_pkg::KIND_TH; g = 24; nir = 6;
                    end
                    else
                        ok = 1'b0;
                end
                psp_pkg::LEAD_O:
                begin
                    ax = 1;
                    if (s.suf == psp_pkg::SUF_NONE)
                    begin
                        k = psp_pkg::KIND_O; g = 24; nir = 5;
                    end
                    else if (s.suf == psp_pkg::SUF_H)
                    begin
                        k = psp_pkg::KIND_OH; g = 48; nir = 10;
                    end
                    else
                        ok = 1'b0;
                end
                psp_pkg::LEAD_I:
                begin
                    ax = 1;
                    if (s.suf == psp_pkg::SUF_NONE)
                    begin
                        k = psp_pkg::KIND_I; g = 60; nir = 5;
                    end
                    else if (s.suf == psp_pkg::SUF_H)
                    begin
                        k = psp_pkg::KIND_IH; g = 120; nir = 10;
                    end
                    else
                        ok = 1'b0;
                end
                default:
                    ok = 1'b0;
            endcase
        end
        if (!ok)
        begin
            r = '0;
        end
        else
        begin
            r.valid_res   = 1'b1;
            r.group_kind  = k;
            r.group_order = psp_pkg::GORD_W'(g);
            r.axis_order  = psp_pkg::AXIS_W'(ax);
            r.irrep_count = psp_pkg::IRREP_W'(nir);
        end
        return r;
    endfunction

    // Advance the mirrored parser by one accepted character
    function automatic void parse_char(psp_pkg::sym_t item);
        logic [7:0] c;
        int unsigned v;
        c = item.ch;
        if (c >= "A" && c <= "Z")
            c = c + 8'd32;
        if (scan.pos == 3'd0)
        begin
            scan.lead = lead_of(c);
            if (scan.lead == psp_pkg::LEAD_OTHER)
                scan.bad = 1'b1;
        end
        else if (scan.lead == psp_pkg::LEAD_C || scan.lead == psp_pkg::LEAD_D
                 || scan.lead == psp_pkg::LEAD_S)
        begin
            if (scan.suf == psp_pkg::SUF_NONE)
            begin
                if (c >= "0" && c <= "9")
                begin
                    if (!scan.ovf)
                    begin
                        v = scan.acc * 10 + (c - 8'h30);
                        if (v > psp_pkg::AXIS_MAX)
                            scan.ovf = 1'b1;
                        else
                            scan.acc = psp_pkg::AXIS_BITS'(v);
                    end
                    scan.dig = 1'b1;
                end
                else
                    scan.suf = suffix_of(c);
            end
        end
        else if (scan.lead == psp_pkg::LEAD_T || scan.lead == psp_pkg::LEAD_O
                 || scan.lead == psp_pkg::LEAD_I)
        begin
            if (scan.pos == 3'd1)
                scan.suf = suffix_of(c);
        end
        if (scan.pos != 3'd7)
            scan.pos = scan.pos + 3'd1;
        if (item.last)
        begin
            groups_due.push_back(classify(scan));
            scan = SCAN_IDLE;
        end
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endfunction

    // Queue one symbol, marking its final character
    function automatic void send_text(logic [7:0] text[$]);
        psp_pkg::sym_t item;
        foreach (text[i])
        begin
            item.ch = text[i];
            item.last = (i == text.size() - 1);
            chars_to_send.push_back(item);
        end
    endfunction

    function automatic void send_word(string s);
        logic [7:0] text[$];
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        send_text(text);
    endfunction

    function automatic void append_word(ref logic [7:0] text[$], input string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endfunction

    // Build one symbol: mostly well-formed groups, some broken ones and noise
    function automatic void random_symbol();
        logic [7:0] text[$];
        string leads;
        string sufs;
        int pick;
        int n;
        pick = $urandom_range(99);
        leads = "cdstoi";
        sufs = "vhdis";
        if (pick < 15)
        begin
            repeat ($urandom_range(1, 8))
                text.push_back(8'($urandom_range(0, 255)));
        end
        else if (pick < 23)
        begin
            case ($urandom_range(2))
                0:       append_word(text, "c1");
                1:       append_word(text, "ci");
                default: append_word(text, "cs");
            endcase
        end
        else if (pick < 78)
        begin
            text.push_back(leads[$urandom_range(2)]);
            case ($urandom_range(19))
                0:       n = -1;
                1, 2:    n = $urandom_range(0, 999);
                3:       n = 0;
                default: n = $urandom_range(1, 12);
            endcase
            if (n >= 0)
            begin
                if ($urandom_range(9) == 0)
                    text.push_back("0");
                append_word(text, $sformatf("%0d", n));
            end
            case ($urandom_range(9))
                0, 1, 2: ;
                3:       text.push_back(8'($urandom_range(0, 255)));
                default: text.push_back(sufs[$urandom_range(4)]);
            endcase
        end
        else
        begin
            text.push_back(leads[$urandom_range(3, 5)]);
            case ($urandom_range(9))
                0, 1, 2: ;
                3:       text.push_back(8'($urandom_range(0, 255)));
                4:       text.push_back(8'($urandom_range("0", "9")));
                default: text.push_back(sufs[$urandom_range(4)]);
            endcase
        end
        // tail characters, which the parser ignores only once a suffix has been read
        if (pick >= 15 && $urandom_range(3) == 0)
        begin
            repeat ($urandom_range(1, 4))
                text.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range("a", "z")));
        end
        // mix upper and lower case letters
        foreach (text[i])
        begin
            if (text[i] >= "a" && text[i] <= "z" && $urandom_range(1))
                text[i] = text[i] - 8'd32;
        end
        send_text(text);
    endfunction

    // Drive character requests from the pending queue
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sym_valid && sym_ready)
                parse_char(sym);
            if (!sym_valid || sym_ready)
            begin
                if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    sym_valid <= 1'b1;
                    sym <= chars_to_send.pop_front();
                end
                else
                    sym_valid <= 1'b0;
            end
        end
    end

    // Check each result request against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (groups_due.size() == 0)
                begin
                    $error("result with no symbol pending: %p", res);
                    failures++;
                end
                else
                begin
                    group_want = groups_due.pop_front();
                    check_field("valid_res", group_want.valid_res, res.valid_res);
                    check_field("group_kind", group_want.group_kind, res.group_kind);
                    check_field("group_order", group_want.group_order, res.group_order);
                    check_field("axis_order", group_want.axis_order, res.axis_order);
                    check_field("irrep_count", group_want.irrep_count, res.irrep_count);
                end
            end
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stop a run that makes no progress
    always @(posedge clk)
    begin
        if ((sym_valid && sym_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("FAIL point_group_symbol_parser");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corner symbols: exact names, widest axis, zero and overflowing orders
        send_word("C1");
        send_word("ci");
        send_word("cs");
        send_word("c01");
        send_word("c255h");
        send_word("d0");
        send_word("D");
        send_word("s256");
        send_word("s3");
        send_word("tD");
        send_word("i4");
        send_text({8'h00, 8'hFF});

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = send_idle_by_phase[p];
            recv_stall_pct = recv_stall_by_phase[p];
            while (chars_to_send.size() < PHASE_CHARS)
                random_symbol();
            // hold new symbols until every pending result is out
            while (chars_to_send.size() != 0 || sym_valid || groups_due.size() != 0)
                @(negedge clk);
        end

        repeat (10) @(posedge clk);
        if (failures == 0 && groups_due.size() == 0)
            $display("PASS point_group_symbol_parser");
        else
            $display("FAIL point_group_symbol_parser");
        $finish;
    end

endmodule

// File: filelist.f
sv/psp_pkg.sv
sv/psp_in_reg.sv
sv/psp_scan.sv
sv/psp_finish.sv
sv/point_group_symbol_parser.sv
dv/tb_top.sv
